// ===== rtl/sct_pkg.sv =====
// ----------------------------------------------------------------------------
// sct_pkg
// Types and constants shared by the sorted record table engine.
// ----------------------------------------------------------------------------
package sct_pkg;

    localparam int DEPTH_DEFAULT = 64;
    localparam int QUEUE_DEPTH   = 2;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_SEARCH = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_CIRCLE = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_NONE  = 2'd2,
        ST_FOUND = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]         command;
        logic [15:0]        key_head;
        logic [63:0]        key_tail;
        logic signed [15:0] coord_x;
        logic signed [15:0] coord_y;
        logic [14:0]        radius;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [15:0]        found_head;
        logic [63:0]        found_tail;
        logic signed [15:0] found_x;
        logic signed [15:0] found_y;
        logic               last;
    } out_item_t;

    typedef struct packed {
        logic [15:0]        head;
        logic [63:0]        tail;
        logic signed [15:0] x;
        logic signed [15:0] y;
    } rec_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_BS_REQ,
        S_BS_CMP,
        S_CHK_REQ,
        S_CHK_CMP,
        S_INS_RD,
        S_INS_WR,
        S_DEL_RD,
        S_DEL_WR,
        S_CIR_RD,
        S_CIR_SQ,
        S_CIR_CMP,
        S_EMIT
    } state_t;

endpackage

// ===== rtl/sct_front.sv =====
// ----------------------------------------------------------------------------
// sct_front
// Accepts command items and holds them in a short queue for the back end.
// ----------------------------------------------------------------------------
module sct_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  sct_pkg::in_item_t cmd_in,
    output logic              busy,
    output logic              q_valid,
    output sct_pkg::in_item_t q_item,
    input  logic              q_pop
);
    import sct_pkg::*;

    in_item_t   slot_reg [QUEUE_DEPTH];
    logic [$clog2(QUEUE_DEPTH+1)-1:0] cnt_reg, cnt_next;
    logic       rd_reg, wr_reg;
    logic       push;

    assign busy    = (cnt_reg == QUEUE_DEPTH[$clog2(QUEUE_DEPTH+1)-1:0]);
    assign push    = start && !busy;
    assign q_valid = (cnt_reg != '0);
    assign q_item  = slot_reg[rd_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !(q_pop && q_valid))
            cnt_next = cnt_reg + 1'b1;
        else if (!push && q_pop && q_valid)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
                wr_reg <= ~wr_reg;
            if (q_pop && q_valid)
                rd_reg <= ~rd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_reg] <= cmd_in;
    end

endmodule

// ===== rtl/sct_back.sv =====
// ----------------------------------------------------------------------------
// sct_back
// Executes queued items on the sorted record memory, one at a time.
// ----------------------------------------------------------------------------
module sct_back #(
    parameter int DEPTH = sct_pkg::DEPTH_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  sct_pkg::in_item_t  q_item,
    output logic               q_pop,
    output logic               done,
    output sct_pkg::out_item_t result
);
    import sct_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    rec_t mem [DEPTH];
    rec_t rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    rec_t          wr_data;

    state_t state_reg, state_next;
    in_item_t item_reg, item_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] lo_reg, lo_next, hi_reg, hi_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic          any_reg, any_next;
    logic          done_reg, done_next;
    out_item_t     res_reg, res_next;
    logic [CW-1:0] mid;
    logic [79:0]   mkey, ikey;
    logic signed [16:0] dx, dy;
    logic [33:0]   dx2_reg, dy2_reg, r2_reg, dx2_next, dy2_next, r2_next;
    logic          match;
    // match record kept one step behind so the final one can carry last
    rec_t          hold_reg;

    assign mid  = CW'((({1'b0, lo_reg} + {1'b0, hi_reg}) >> 1));
    assign mkey = {rd_data_reg.head, rd_data_reg.tail};
    assign ikey = {item_reg.key_head, item_reg.key_tail};
    assign dx   = 17'(rd_data_reg.x) - 17'(item_reg.coord_x);
    assign dy   = 17'(rd_data_reg.y) - 17'(item_reg.coord_y);
    assign match = (dx2_reg + dy2_reg) <= r2_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        state_next = state_reg;
        item_next  = item_reg;
        count_next = count_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        idx_next   = idx_reg;
        any_next   = any_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        dx2_next   = dx2_reg;
        dy2_next   = dy2_reg;
        r2_next    = r2_reg;
        q_pop      = 1'b0;
        rd_addr    = '0;
        wr_en      = 1'b0;
        wr_addr    = '0;
        wr_data    = rd_data_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop     = 1'b1;
                    item_next = q_item;
                    lo_next   = '0;
                    hi_next   = count_reg;
                    any_next  = 1'b0;
                    idx_next  = '0;
                    res_next  = '0;
                    res_next.last = 1'b1;
                    r2_next   = 34'(q_item.radius) * 34'(q_item.radius);
                    if (q_item.command == CMD_INSERT &&
                        count_reg == DEPTH[CW-1:0])
                    begin
                        res_next.status = ST_FULL;
                        state_next = S_EMIT;
                    end
                    else if (q_item.command == CMD_CIRCLE)
                        state_next = S_CIR_RD;
                    else
                        state_next = S_BS_REQ;
                end
            end
            S_BS_REQ:
            begin
                if (lo_reg < hi_reg)
                begin
                    rd_addr    = mid[AW-1:0];
                    state_next = S_BS_CMP;
                end
                else if (item_reg.command == CMD_INSERT)
                begin
                    idx_next   = count_reg;
                    state_next = S_INS_RD;
                end
                else
                    state_next = S_CHK_REQ;
            end
            S_BS_CMP:
            begin
                // insert seeks the upper bound, search/delete the lower bound
                if ((item_reg.command == CMD_INSERT) ? (mkey <= ikey) : (mkey < ikey))
                    lo_next = mid + 1'b1;
                else
                    hi_next = mid;
                state_next = S_BS_REQ;
            end
            S_CHK_REQ:
            begin
                rd_addr = lo_reg[AW-1:0];
                if (lo_reg >= count_reg)
                begin
                    res_next.status = ST_NONE;
                    state_next = S_EMIT;
                end
                else
                    state_next = S_CHK_CMP;
            end
            S_CHK_CMP:
            begin
                if (mkey != ikey)
                begin
                    res_next.status = ST_NONE;
                    state_next = S_EMIT;
                end
                else if (item_reg.command == CMD_SEARCH)
                begin
                    res_next.status     = ST_FOUND;
                    res_next.found_head = rd_data_reg.head;
                    res_next.found_tail = rd_data_reg.tail;
                    res_next.found_x    = rd_data_reg.x;
                    res_next.found_y    = rd_data_reg.y;
                    state_next = S_EMIT;
                end
                else
                begin
                    idx_next   = lo_reg;
                    state_next = S_DEL_RD;
                end
            end
            S_INS_RD:
            begin
                // shift entries up from the top down to the insert point
                if (idx_reg > lo_reg)
                begin
                    rd_addr    = AW'(idx_reg - 1'b1);
                    state_next = S_INS_WR;
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_addr    = lo_reg[AW-1:0];
                    wr_data    = '{item_reg.key_head, item_reg.key_tail,
                                   item_reg.coord_x, item_reg.coord_y};
                    count_next = count_reg + 1'b1;
                    res_next.status = ST_DONE;
                    state_next = S_EMIT;
                end
            end
            S_INS_WR:
            begin
                wr_en      = 1'b1;
                wr_addr    = idx_reg[AW-1:0];
                idx_next   = idx_reg - 1'b1;
                state_next = S_INS_RD;
            end
            S_DEL_RD:
            begin
                if (CW'(idx_reg + 1'b1) < count_reg)
                begin
                    rd_addr    = AW'(idx_reg + 1'b1);
                    state_next = S_DEL_WR;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                    res_next.status = ST_DONE;
                    state_next = S_EMIT;
                end
            end
            S_DEL_WR:
            begin
                wr_en      = 1'b1;
                wr_addr    = idx_reg[AW-1:0];
                idx_next   = idx_reg + 1'b1;
                state_next = S_DEL_RD;
            end
            S_CIR_RD:
            begin
                if (idx_reg < count_reg)
                begin
                    rd_addr    = idx_reg[AW-1:0];
                    state_next = S_CIR_SQ;
                end
                else
                begin
                    if (!any_reg)
                    begin
                        res_next = '0;
                        res_next.status = ST_NONE;
                        res_next.last   = 1'b1;
                        done_next = 1'b1;
                    end
                    else
                    begin
                        // flush the held match as the final result
                        res_next.status     = ST_FOUND;
                        res_next.found_head = hold_reg.head;
                        res_next.found_tail = hold_reg.tail;
                        res_next.found_x    = hold_reg.x;
                        res_next.found_y    = hold_reg.y;
                        res_next.last       = 1'b1;
                        done_next = 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end
            S_CIR_SQ:
            begin
                // keep the record on the read port for the compare step
                rd_addr    = idx_reg[AW-1:0];
                dx2_next   = 34'(dx * dx);
                dy2_next   = 34'(dy * dy);
                state_next = S_CIR_CMP;
            end
            S_CIR_CMP:
            begin
                if (match)
                begin
                    // emit previously held match, then hold this one
                    if (any_reg)
                    begin
                        res_next.status     = ST_FOUND;
                        res_next.found_head = hold_reg.head;
                        res_next.found_tail = hold_reg.tail;
                        res_next.found_x    = hold_reg.x;
                        res_next.found_y    = hold_reg.y;
                        res_next.last       = 1'b0;
                        done_next = 1'b1;
                    end
                    any_next = 1'b1;
                end
                idx_next   = idx_reg + 1'b1;
                state_next = S_CIR_RD;
            end
            S_EMIT:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
            any_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
            any_reg   <= any_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        idx_reg  <= idx_next;
        dx2_reg  <= dx2_next;
        dy2_reg  <= dy2_next;
        r2_reg   <= r2_next;
        res_reg  <= res_next;
        if (state_reg == S_CIR_CMP && match)
            hold_reg <= rd_data_reg;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

// ===== rtl/sorted_city_table_engine_unit.sv =====
// ----------------------------------------------------------------------------
// sorted_city_table_engine_unit
// Sorted name table with insert, search, delete and circle query.
// ----------------------------------------------------------------------------
// Usage: drive cmd with start; the item is taken on a clock edge where start
// is high and busy is low. A two-entry queue holds items until the executor
// is free, so busy rises only when both slots are full.
// Results appear on result for one cycle with valid high; last marks the
// final result of an item. The receiver cannot stall the block.
// Work per item, from the executor picking it up:
//   search/delete lookup: each binary search step is a read, then a compare;
//   insert adds a read and a write per entry shifted up, delete the same per
//   entry shifted down; circle query reads, squares and compares each stored
//   record. All set by the one read and one write port of the record memory.
// Reset empties the table (count to zero) and the queue; the record memory
// itself is not cleared.
// ----------------------------------------------------------------------------
module sorted_city_table_engine_unit #(
    parameter int DEPTH = sct_pkg::DEPTH_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  sct_pkg::in_item_t  cmd,
    output logic               busy,
    output logic               valid,
    output sct_pkg::out_item_t result
);
    import sct_pkg::*;

    logic     q_valid, q_pop;
    in_item_t q_item;

    sct_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .cmd_in  (cmd),
        .busy    (busy),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop)
    );

    sct_back #(.DEPTH(DEPTH)) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop),
        .done    (valid),
        .result  (result)
    );

endmodule

// ===== rtl/sct_checker.sv =====
// ----------------------------------------------------------------------------
// sct_checker
// Port-level checks for the sorted table engine.
// ----------------------------------------------------------------------------
module sct_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               valid,
    input sct_pkg::out_item_t result
);
    import sct_pkg::*;

    // non-record results carry zero payload
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        valid && result.status != ST_FOUND |->
            result.found_head == '0 && result.found_tail == '0)
        else $error("payload not zero");

    // done, full and not-found always end the item
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        valid && result.status != ST_FOUND |-> result.last)
        else $error("single result without last");

    // no output straight after reset release
    a_reset: assert property (@(posedge clk)
        !rst_n |=> !valid)
        else $error("valid after reset");

    // a non-final result is a found record; more results of the same query follow
    a_cont: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !result.last |-> result.status == ST_FOUND)
        else $error("non-last result not a record");

    // the queue only fills up on an accepted item
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without an item");

endmodule

bind sorted_city_table_engine_unit sct_checker u_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .valid  (valid),
    .result (result)
);
